@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion helper macros shared by the design files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on the rising edge of clk outside reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mm_pkg.sv @@
// ---------------------------------------------------------------------------
// mm_pkg
// shared types, codes and constants of the matrix multiply block
// ---------------------------------------------------------------------------
package mm_pkg;

  // default sizes
  localparam int MAX_DIM_DEF   = 8;
  localparam int DATA_BITS_DEF = 16;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int VAL_W   = 16;
  localparam int RES_W   = 35;
  localparam int POS_W   = 3;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 2'd2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } state_t;

  // input request
  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] element_value;
  } item_t;

  // result request
  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic [POS_W-1:0]        result_row;
    logic [POS_W-1:0]        result_col;
    logic                    last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic write_a;
    logic write_b;
    logic start;
    logic issue;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic p_last;
    logic elem_last;
    logic busy;
    logic out_free;
    logic dims_empty;
    logic k_zero;
  } status_t;

endpackage

@@ design/matrix_multiply.sv @@
// ---------------------------------------------------------------------------
// matrix_multiply
// out = A x B on row-major operand stores, exact fixed-point sums
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    item_t (load A, load B, compute)
//   result    out        result_valid / result_stall result_t (sum, row, col, last)
//   config    in         cfg_write                  cfg_index, cfg_data
//
// a load request is written while idle, without a stall; a compute request holds
// the input until its last sum is loaded: per sum, reads of k operand pairs from
// the two stores, then the read and multiply stages empty, then the result
// register is loaded. with k of zero nothing is read and each sum is loaded as
// soon as the result register is free. the result register frees the datapath:
// the next sum starts while one waits to be taken, and a stalled result only
// holds things up once the next is done. reset is synchronous and restores the
// dimensions to 8 by 8 by 8; the stores are not cleared.
//
module matrix_multiply #(
  parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
  parameter int DATA_BITS = mm_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mm_pkg::CFG_W-1:0]      cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  mm_pkg::item_t                 item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output mm_pkg::result_t               result
);

  import mm_pkg::*;

  `include "assert_macros.svh"

  cmd_t    cmd;
  status_t status;

  // controller
  mm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .operation  (item.operation),
    .status     (status),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  // datapath
  mm_datapath #(.MAX_DIM(MAX_DIM), .DATA_BITS(DATA_BITS)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .result_stall (result_stall),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

  // checks
  `CHK_IMPLY(a_load_drained, cmd.load_out, !status.busy, "result loaded before products done")
  `CHK_IMPLY(a_idle_empty, !item_stall, !status.busy && !cmd.issue, "pipeline active while idle")
  `CHK_IMPLY(a_no_overwrite, cmd.load_out, !result_valid || !result_stall, "result overwritten")
  `CHK_NEXT(a_issue_reads, cmd.issue, status.busy, "read not tracked in pipeline")

endmodule

@@ design/mm_ram.sv @@
// ---------------------------------------------------------------------------
// mm_ram
// simple dual-port ram: one write port, one registered read port
// ---------------------------------------------------------------------------
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/mm_ctrl.sv @@
// ---------------------------------------------------------------------------
// mm_ctrl
// sequencer: takes requests, steps the multiply-accumulate per result
// ---------------------------------------------------------------------------
module mm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic [mm_pkg::OP_W-1:0]       operation,
  input  mm_pkg::status_t               status,
  output logic                          item_stall,
  output mm_pkg::cmd_t                  cmd
);

  import mm_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && operation == OP_COMPUTE && !status.dims_empty) begin
          state_next = status.k_zero ? ST_DRAIN : ST_MAC;
        end
      end
      ST_MAC: begin
        if (status.p_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.busy && status.out_free) begin
          if (status.elem_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = status.k_zero ? ST_DRAIN : ST_MAC;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          case (operation)
            OP_LOAD_A:  cmd.write_a = 1'b1;
            OP_LOAD_B:  cmd.write_b = 1'b1;
            OP_COMPUTE: cmd.start   = !status.dims_empty;
            default:    cmd         = '0;
          endcase
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd.load_out = !status.busy && status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ design/mm_datapath.sv @@
// ---------------------------------------------------------------------------
// mm_datapath
// operand stores, address counters, multiplier, accumulator, result register
// ---------------------------------------------------------------------------
module mm_datapath #(
  parameter int MAX_DIM   = 8,
  parameter int DATA_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mm_pkg::CFG_W-1:0]      cfg_data,
  input  mm_pkg::item_t                 item,
  input  mm_pkg::cmd_t                  cmd,
  input  logic                          result_stall,
  output mm_pkg::status_t               status,
  output logic                          result_valid,
  output mm_pkg::result_t               result
);

  import mm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PROD_W = 2 * DATA_BITS;

  logic [CFG_W-1:0] rows_m;
  logic [CFG_W-1:0] inner_k;
  logic [CFG_W-1:0] cols_n;
  logic [DIM_W-1:0] dim_m;
  logic [DIM_W-1:0] dim_k;
  logic [DIM_W-1:0] dim_n;

  logic [CNT_W-1:0]  p;
  logic [CNT_W-1:0]  i;
  logic [CNT_W-1:0]  j;
  logic [ADDR_W-1:0] a_row;
  logic [ADDR_W-1:0] a_ptr;
  logic [ADDR_W-1:0] b_ptr;
  logic              j_last;

  logic              wr_ok;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_BITS-1:0] wr_data;
  logic [DATA_BITS-1:0] a_q;
  logic [DATA_BITS-1:0] b_q;

  logic                     rd_vld;
  logic                     mul_vld;
  logic signed [PROD_W-1:0] prod;
  logic [RES_W-1:0]         acc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m  <= DIM_RESET;
      inner_k <= DIM_RESET;
      cols_n  <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROWS_M:  rows_m  <= cfg_data;
        CFG_INNER_K: inner_k <= cfg_data;
        CFG_COLS_N:  cols_n  <= cfg_data;
        default:     rows_m  <= rows_m;
      endcase
    end
  end

  // dimensions saturate at MAX_DIM, the side of the square stores
  assign dim_m = (rows_m  > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_m);
  assign dim_k = (inner_k > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(inner_k);
  assign dim_n = (cols_n  > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_n);

  // load path, out-of-range indexes dropped
  assign wr_ok   = item.element_index < DEPTH;
  assign wr_addr = ADDR_W'(item.element_index);
  assign wr_data = DATA_BITS'(item.element_value);

  mm_ram #(.WIDTH(DATA_BITS), .DEPTH(DEPTH)) u_store_a (
    .clk     (clk),
    .wr_en   (cmd.write_a && wr_ok),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.issue),
    .rd_addr (a_ptr),
    .rd_data (a_q)
  );

  mm_ram #(.WIDTH(DATA_BITS), .DEPTH(DEPTH)) u_store_b (
    .clk     (clk),
    .wr_en   (cmd.write_b && wr_ok),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.issue),
    .rd_addr (b_ptr),
    .rd_data (b_q)
  );

  assign j_last = DIM_W'(j) == dim_n - DIM_W'(1);

  // index and address counters: a at i*k+p, b at p*n+j
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p     <= '0;
      i     <= '0;
      j     <= '0;
      a_row <= '0;
      a_ptr <= '0;
      b_ptr <= '0;
    end else if (cmd.issue) begin
      p     <= p + CNT_W'(1);
      a_ptr <= a_ptr + ADDR_W'(1);
      b_ptr <= b_ptr + ADDR_W'(dim_n);
    end else if (cmd.load_out) begin
      p <= '0;
      if (j_last) begin
        j     <= '0;
        i     <= i + CNT_W'(1);
        a_row <= a_row + ADDR_W'(dim_k);
        a_ptr <= a_row + ADDR_W'(dim_k);
        b_ptr <= '0;
      end else begin
        j     <= j + CNT_W'(1);
        a_ptr <= a_row;
        b_ptr <= ADDR_W'(j) + ADDR_W'(1);
      end
    end
  end

  // pipeline valid flags: read, then multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
    end else begin
      rd_vld  <= cmd.issue;
      mul_vld <= rd_vld;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= $signed(a_q) * $signed(b_q);
    end
  end

  // accumulator, wraps at the result width
  always_ff @(posedge clk) begin
    if (cmd.start || cmd.load_out) begin
      acc <= '0;
    end else if (mul_vld) begin
      acc <= acc + RES_W'(prod);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.result_value <= acc;
      result.result_row   <= POS_W'(i);
      result.result_col   <= POS_W'(j);
      result.last         <= status.elem_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // status to the controller
  assign status.p_last     = DIM_W'(p) == dim_k - DIM_W'(1);
  assign status.elem_last  = (DIM_W'(i) == dim_m - DIM_W'(1)) && j_last;
  assign status.busy       = rd_vld || mul_vld;
  assign status.out_free   = !result_valid || !result_stall;
  assign status.dims_empty = (dim_m == '0) || (dim_n == '0);
  assign status.k_zero     = dim_k == '0;

endmodule

@@ bench/matrix_multiply_tb.sv @@
// ---------------------------------------------------------------------------
// matrix_multiply_tb
// self-checking bench: load and compute requests in bursts, random result
// stalls, scoreboard with its own operand stores and dimensions
// ---------------------------------------------------------------------------
module matrix_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mm_pkg::*;

  localparam int STORE_DEPTH   = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int RANDOM_ITEMS  = 200;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int TIMEOUT_NS    = 10_000_000;
  localparam int REPORT_LIMIT  = 30;

  localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [VAL_W-1:0]     VAL_MIN   = 16'h8000;
  localparam logic [VAL_W-1:0]     VAL_MAX   = 16'h7FFF;
  localparam logic [VAL_W-1:0]     VAL_ZERO  = 16'h0000;
  localparam logic [VAL_W-1:0]     VAL_ONES  = 16'hFFFF;

  // expected sums of the result matrix, built from private operand stores
  class gemm_scoreboard;
    logic signed [VAL_W-1:0] a_elems[STORE_DEPTH];
    logic signed [VAL_W-1:0] b_elems[STORE_DEPTH];
    int unsigned rows;
    int unsigned inner;
    int unsigned cols;
    result_t pending_sums[$];
    int fails;
    int loads;
    int computes;
    int ignored;
    int sums_seen;

    function new();
      rows = int'(DIM_RESET);
      inner = int'(DIM_RESET);
      cols = int'(DIM_RESET);
      fails = 0;
      loads = 0;
      computes = 0;
      ignored = 0;
      sums_seen = 0;
    endfunction

    // dimensions above MAX_DIM_DEF saturate to it
    function int dim_used(int unsigned raw);
      return (raw > MAX_DIM_DEF) ? MAX_DIM_DEF : raw;
    endfunction

    function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_ROWS_M:  rows = int'(val);
        CFG_INNER_K: inner = int'(val);
        CFG_COLS_N:  cols = int'(val);
        default: ;
      endcase
    endfunction

    task report(string what);
      fails++;
      if (fails <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // queue one exact sum per result element, row-major
    function void predict_product();
      int me;
      int ke;
      int ne;
      longint acc;
      longint av;
      longint bv;
      result_t s;
      me = dim_used(rows);
      ke = dim_used(inner);
      ne = dim_used(cols);
      for (int i = 0; i < me; i++) begin
        for (int j = 0; j < ne; j++) begin
          acc = 0;
          for (int p = 0; p < ke; p++) begin
            av = longint'(a_elems[i * ke + p]);
            bv = longint'(b_elems[p * ne + j]);
            acc += av * bv;
          end
          s.result_value = acc[RES_W-1:0];
          s.result_row = POS_W'(i);
          s.result_col = POS_W'(j);
          s.last = (i == me - 1) && (j == ne - 1);
          pending_sums.push_back(s);
        end
      end
    endfunction

    task note_item(item_t req);
      case (op_t'(req.operation))
        OP_LOAD_A: begin
          a_elems[req.element_index] = req.element_value;
          loads++;
        end
        OP_LOAD_B: begin
          b_elems[req.element_index] = req.element_value;
          loads++;
        end
        OP_COMPUTE: begin
          predict_product();
          computes++;
        end
        default: ignored++;
      endcase
    endtask

    task check_result(result_t got);
      result_t want;
      sums_seen++;
      if (pending_sums.size() == 0) begin
        report($sformatf("result row %0d col %0d with no sum expected",
                         got.result_row, got.result_col));
        return;
      end
      want = pending_sums.pop_front();
      if (got.result_value !== want.result_value)
        report($sformatf("sum at (%0d,%0d): got %0d, want %0d", want.result_row,
                         want.result_col, got.result_value, want.result_value));
      if (got.result_row !== want.result_row)
        report($sformatf("row: got %0d, want %0d", got.result_row, want.result_row));
      if (got.result_col !== want.result_col)
        report($sformatf("col: got %0d, want %0d", got.result_col, want.result_col));
      if (got.last !== want.last)
        report($sformatf("last at (%0d,%0d): got %0b, want %0b", want.result_row,
                         want.result_col, got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;

  gemm_scoreboard sb;
  bit a_written[STORE_DEPTH];
  bit b_written[STORE_DEPTH];
  bit hold_off_req;
  int burst_left;
  int work_items;
  int phases;

  matrix_multiply u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // accepted requests in both directions
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on demand
  initial begin
    int seg;
    int mode;
    int hold;
    int tick;
    logic stall_now;
    seg = 0;
    mode = 0;
    hold = 0;
    tick = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        stall_now = 1'b1;
      end else begin
        if (seg == 0) begin
          mode = $urandom_range(0, 3);
          seg = $urandom_range(10, 80);
        end
        seg--;
        case (mode)
          0: stall_now = 1'b0;
          1: stall_now = ($urandom_range(0, 3) == 0);
          2: stall_now = ($urandom_range(0, 3) != 0);
          default: stall_now = (tick % 4 == 3);
        endcase
      end
      result_stall <= stall_now;
    end
  end

  // hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("timeout: results still outstanding");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return VAL_ZERO;
      3: return VAL_ONES;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // mostly small sizes, now and then empty, full or saturating
  function automatic logic [CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return CFG_W'($urandom_range(9, 15));
    if (r < 16) return CFG_W'(MAX_DIM_DEF);
    return CFG_W'($urandom_range(1, 4));
  endfunction

  // offer one request, then either stay in the burst or leave a gap
  task automatic send_request(input item_t req);
    item <= req;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic send_load(input op_t op, input int idx, input logic [VAL_W-1:0] val);
    item_t req;
    req.operation = op;
    req.element_index = IDX_W'(idx);
    req.element_value = val;
    send_request(req);
    if (op == OP_LOAD_A) a_written[idx] = 1'b1;
    else b_written[idx] = 1'b1;
  endtask

  // compute or unused code, with random filler in the ignored fields
  task automatic send_other(input logic [OP_W-1:0] code);
    item_t req;
    req.operation = code;
    req.element_index = IDX_W'($urandom);
    req.element_value = VAL_W'($urandom);
    send_request(req);
  endtask

  // wait for every expected sum, then let the block settle
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(input logic [CFG_W-1:0] m, k, n, input bit poke_spare);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ROWS_M;
    cfg_data <= m;
    @(posedge clk);
    sb.set_dim(CFG_ROWS_M, m);
    cfg_index <= CFG_INNER_K;
    cfg_data <= k;
    @(posedge clk);
    sb.set_dim(CFG_INNER_K, k);
    cfg_index <= CFG_COLS_N;
    cfg_data <= n;
    @(posedge clk);
    sb.set_dim(CFG_COLS_N, n);
    if (poke_spare) begin
      cfg_index <= CFG_SPARE;
      cfg_data <= junk;
      @(posedge clk);
      sb.set_dim(CFG_SPARE, junk);
    end
    cfg_write <= 1'b0;
  endtask

  // fill what the next compute reads, with a little noise, then compute
  task automatic run_job(input bit all_min);
    int me;
    int ke;
    int ne;
    me = sb.dim_used(sb.rows);
    ke = sb.dim_used(sb.inner);
    ne = sb.dim_used(sb.cols);
    for (int x = 0; x < me * ke; x++) begin
      if (all_min || !a_written[x] || $urandom_range(0, 2) != 0) begin
        send_load(OP_LOAD_A, x, all_min ? VAL_MIN : pick_value());
        work_items++;
      end
    end
    if ($urandom_range(0, 5) == 0) send_other(OP_SPARE);
    for (int x = 0; x < ke * ne; x++) begin
      if (all_min || !b_written[x] || $urandom_range(0, 2) != 0) begin
        send_load(OP_LOAD_B, x, all_min ? VAL_MIN : pick_value());
        work_items++;
      end
    end
    if ($urandom_range(0, 6) == 0) begin
      send_load(op_t'($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A),
                $urandom_range(0, STORE_DEPTH - 1), pick_value());
      work_items++;
    end
    send_other(OP_COMPUTE);
    work_items++;
    if ($urandom_range(0, 9) == 0) begin
      send_other(OP_COMPUTE);
      work_items++;
    end
  endtask

  // main sequence
  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_ROWS_M;
    cfg_data <= '0;
    item_valid <= 1'b0;
    item <= '0;
    hold_off_req = 1'b0;
    burst_left = 0;
    work_items = 0;
    phases = 0;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 2x2x2 with extreme operands and an unused code in the stream
    write_dims(4'd2, 4'd2, 4'd2, 1'b1);
    send_load(OP_LOAD_A, 0, VAL_MIN);
    send_load(OP_LOAD_A, 1, VAL_MAX);
    send_load(OP_LOAD_A, 2, VAL_ZERO);
    send_load(OP_LOAD_A, 3, VAL_ONES);
    send_load(OP_LOAD_B, 0, VAL_MIN);
    send_load(OP_LOAD_B, 1, VAL_ONES);
    send_load(OP_LOAD_B, 2, VAL_MAX);
    send_load(OP_LOAD_B, 3, VAL_MIN);
    send_other(OP_SPARE);
    send_other(OP_COMPUTE);
    drain_results();

    // zero inner dimension gives all-zero sums
    write_dims(4'd2, 4'd0, 4'd2, 1'b0);
    send_other(OP_COMPUTE);
    drain_results();

    // zero rows, then zero columns: no results at all
    write_dims(4'd0, 4'd2, 4'd2, 1'b0);
    send_other(OP_COMPUTE);
    drain_results();
    write_dims(4'd2, 4'd2, 4'd0, 1'b1);
    send_other(OP_COMPUTE);
    drain_results();

    // oversize rows and columns saturate to a full 8x8 result
    write_dims(4'd9, 4'd1, 4'd15, 1'b0);
    for (int x = 4; x < 8; x++) send_load(OP_LOAD_A, x, x[0] ? VAL_MAX : VAL_MIN);
    for (int x = 4; x < 8; x++) send_load(OP_LOAD_B, x, x[0] ? VAL_MIN : VAL_ONES);
    send_load(OP_LOAD_A, STORE_DEPTH - 1, VAL_ONES);
    send_load(OP_LOAD_B, STORE_DEPTH - 1, VAL_MAX);
    send_other(OP_COMPUTE);
    drain_results();

    // random phases; one of them holds the results back for a long stretch
    while (work_items < RANDOM_ITEMS) begin
      phases++;
      if (phases == 3) begin
        write_dims(4'd4, 4'd2, 4'd4, 1'b0);
        hold_off_req = 1'b1;
        run_job(1'b0);
        run_job(1'b0);
      end else begin
        write_dims(pick_dim(), pick_dim(), pick_dim(), $urandom_range(0, 4) == 0);
        repeat ($urandom_range(1, 3)) run_job($urandom_range(0, 7) == 0);
      end
      drain_results();
    end

    if (sb.pending_sums.size() != 0)
      sb.report($sformatf("%0d sums never arrived", sb.pending_sums.size()));
    $display("covered %0d loads, %0d computes, %0d ignored requests, %0d result elements",
             sb.loads, sb.computes, sb.ignored, sb.sums_seen);
    $display("%0d random dimension settings plus directed corners, one long result hold-off",
             phases);
    if (sb.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
